[hdl/fprf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_pkg
// Shared types and constants for the free page run finder.
// ----------------------------------------------------------------------------
package fprf_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W   = 32;
    localparam int PAGES_W  = 13;
    localparam int CFG_W    = 5;
    localparam int ENTRY_W  = 4;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic start_search;
        logic clear_idx;
        logic next_idx;
        logic take_hit;
        logic load_out;
        logic nf;
    } t_dp_cmd;

    typedef struct packed {
        logic bound_fail;
        logic n_zero;
        logic hit;
        logic hit_fail;
        logic last;
    } t_dp_sts;

endpackage
`default_nettype wire

[hdl/fprf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_dp
// Datapath: range entry memory, count register, search pointer and result.
// ----------------------------------------------------------------------------
module fprf_dp #(
    parameter int MAX_RANGES = fprf_pkg::MAX_RANGES_DEF,
    parameter int PAGE_SHIFT = fprf_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fprf_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [fprf_pkg::ENTRY_W-1:0]   i_entry_index,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_start,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_end,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_search_start,
    input  wire logic [fprf_pkg::PAGES_W-1:0]   i_page_count,
    input  wire fprf_pkg::t_dp_cmd              i_cmd,
    output fprf_pkg::t_dp_sts                   o_sts,
    output logic [fprf_pkg::ADDR_W-1:0]         o_found_address,
    output logic                                o_not_found
);

    localparam int PN_W  = fprf_pkg::ADDR_W - PAGE_SHIFT;
    localparam int P_W   = PN_W + 1;
    localparam int SUM_W = PN_W + 2;
    localparam int ENT_W = PN_W + P_W;
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int N_W   = $clog2(MAX_RANGES + 1);
    localparam logic [SUM_W-1:0] SPACE = SUM_W'(1) << PN_W;
    localparam logic [fprf_pkg::ADDR_W:0] ROUND = (fprf_pkg::ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

    logic [ENT_W-1:0]           mem [MAX_RANGES];
    logic [ENT_W-1:0]           r_rd;
    logic [fprf_pkg::CFG_W-1:0] r_range_count;
    logic [IDX_W-1:0]           r_idx;
    logic [P_W-1:0]             r_p;
    logic [fprf_pkg::PAGES_W-1:0] r_pages;
    logic [N_W-1:0]             r_n;

    logic [fprf_pkg::ADDR_W:0]  end_round;
    logic [P_W-1:0]             wr_end;
    logic [PN_W-1:0]            wr_start;
    logic [7:0]                 cnt_ext;
    logic [N_W-1:0]             n_sat;
    logic [PN_W-1:0]            rd_s;
    logic [P_W-1:0]             rd_e;
    logic [SUM_W-1:0]           sum_p;
    logic [SUM_W-1:0]           sum_e;
    logic                       wr_ok;

    assign end_round = {1'b0, i_range_end} + ROUND;
    assign wr_end    = end_round[fprf_pkg::ADDR_W:PAGE_SHIFT];
    assign wr_start  = i_range_start[fprf_pkg::ADDR_W-1:PAGE_SHIFT];
    assign wr_ok     = 32'(i_entry_index) < 32'(MAX_RANGES);
    assign cnt_ext   = 8'(r_range_count);
    assign n_sat     = (cnt_ext > 8'(MAX_RANGES)) ? N_W'(MAX_RANGES) : N_W'(r_range_count);

    assign rd_s  = r_rd[PN_W-1:0];
    assign rd_e  = r_rd[ENT_W-1:PN_W];
    assign sum_p = SUM_W'(r_p) + SUM_W'(r_pages);
    assign sum_e = SUM_W'(rd_e) + SUM_W'(r_pages);

    always_comb begin
        o_sts.bound_fail = sum_p > SPACE;
        o_sts.n_zero     = r_n == '0;
        o_sts.hit        = (P_W'(rd_s) < rd_e) && (r_p < rd_e) && (sum_p > SUM_W'(rd_s));
        o_sts.hit_fail   = sum_e > SPACE;
        o_sts.last       = (N_W'(r_idx) + N_W'(1)) == r_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && wr_ok) begin
            mem[IDX_W'(i_entry_index)] <= {wr_end, wr_start};
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= '0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_range_count <= i_cfg_data;
            end
            if (i_cmd.clear_idx) begin
                r_idx <= '0;
            end else if (i_cmd.next_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_search) begin
            r_p     <= P_W'(i_search_start[fprf_pkg::ADDR_W-1:PAGE_SHIFT]);
            r_pages <= i_page_count;
            r_n     <= n_sat;
        end else if (i_cmd.take_hit) begin
            r_p <= rd_e;
        end
        if (i_cmd.load_out) begin
            o_found_address <= i_cmd.nf ? '0 : {r_p[PN_W-1:0], {PAGE_SHIFT{1'b0}}};
            o_not_found     <= i_cmd.nf;
        end
    end

endmodule
`default_nettype wire

[hdl/fprf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_ctrl
// Controller: transaction handshakes and the search walk sequencing.
// ----------------------------------------------------------------------------
module fprf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_func,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire fprf_pkg::t_dp_sts i_sts,
    output fprf_pkg::t_dp_cmd      o_cmd
);

    fprf_pkg::t_state r_state, n_state;
    logic r_moved, n_moved;
    logic r_nf, n_nf;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign o_in_stall  = r_state != fprf_pkg::S_IDLE;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fprf_pkg::S_IDLE;
            r_moved     <= 1'b0;
            r_nf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_moved     <= n_moved;
            r_nf        <= n_nf;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_moved = r_moved;
        n_nf    = r_nf;
        o_cmd   = '0;
        unique case (r_state)
            fprf_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_func == fprf_pkg::FUNC_SEARCH) begin
                        o_cmd.start_search = 1'b1;
                        n_state            = fprf_pkg::S_CHECK;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            fprf_pkg::S_CHECK: begin
                n_moved = 1'b0;
                priority if (i_sts.bound_fail) begin
                    n_nf    = 1'b1;
                    n_state = fprf_pkg::S_DONE;
                end else if (i_sts.n_zero) begin
                    n_nf    = 1'b0;
                    n_state = fprf_pkg::S_DONE;
                end else begin
                    o_cmd.clear_idx = 1'b1;
                    n_state         = fprf_pkg::S_FETCH;
                end
            end
            fprf_pkg::S_FETCH: begin
                n_state = fprf_pkg::S_CMP;
            end
            fprf_pkg::S_CMP: begin
                o_cmd.take_hit = i_sts.hit;
                priority if (i_sts.hit && i_sts.hit_fail) begin
                    n_nf    = 1'b1;
                    n_state = fprf_pkg::S_DONE;
                end else if (i_sts.last) begin
                    if (r_moved || i_sts.hit) begin
                        n_state = fprf_pkg::S_CHECK;
                    end else begin
                        n_nf    = 1'b0;
                        n_state = fprf_pkg::S_DONE;
                    end
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_moved        = r_moved || i_sts.hit;
                    n_state        = fprf_pkg::S_FETCH;
                end
            end
            fprf_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.nf       = r_nf;
                    n_state        = fprf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fprf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == fprf_pkg::FUNC_SEARCH) |=> r_state == fprf_pkg::S_CHECK)
        else $error("search transaction did not start a walk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while pending");

    a_cmp_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fprf_pkg::S_CMP |-> $past(r_state) == fprf_pkg::S_FETCH)
        else $error("compare without memory fetch");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == fprf_pkg::S_DONE)
        else $error("result raised outside done state");

endmodule
`default_nettype wire

[hdl/free_page_run_finder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// free_page_run_finder
// First-fit search for a run of free pages outside a set of reserved ranges.
// ----------------------------------------------------------------------------
// A load transaction (func 0) writes one reserved range entry and returns
// nothing. A search transaction (func 1) walks the first range_count entries
// of the range memory (at most MAX_RANGES), each entry in a fetch state
// (memory read) and then a compare state, and starts a new pass after any
// pass that moved the search pointer. A search makes at most N + 1 passes
// for N valid entries; the range memory is single-port with a registered
// read. Input is stalled while a search is in progress; the result sits in
// an output register, so a new transaction is taken while a result still
// waits.
module free_page_run_finder #(
    parameter int MAX_RANGES = fprf_pkg::MAX_RANGES_DEF,
    parameter int PAGE_SHIFT = fprf_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fprf_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [fprf_pkg::ENTRY_W-1:0]   i_entry_index,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_start,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_end,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_search_start,
    input  wire logic [fprf_pkg::PAGES_W-1:0]   i_page_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [fprf_pkg::ADDR_W-1:0]         o_found_address,
    output logic                                o_not_found
);

    fprf_pkg::t_dp_cmd cmd;
    fprf_pkg::t_dp_sts sts;

    fprf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fprf_dp #(
        .MAX_RANGES (MAX_RANGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_entry_index),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_search_start  (i_search_start),
        .i_page_count    (i_page_count),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found_address (o_found_address),
        .o_not_found     (o_not_found)
    );

endmodule
`default_nettype wire

[dv/fprf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fprf_checker
// Watches the load, search and result channels of the free page run finder.
// ----------------------------------------------------------------------------
// Keeps its own copy of the reserved range table and of range_count, works
// out the first-fit answer of every accepted search and compares each
// accepted result, field by field, with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module fprf_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fprf_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_func,
    input  wire logic [fprf_pkg::ENTRY_W-1:0]   i_entry_index,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_start,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_range_end,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_search_start,
    input  wire logic [fprf_pkg::PAGES_W-1:0]   i_page_count,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [fprf_pkg::ADDR_W-1:0]    i_found_address,
    input  wire logic                           i_not_found,
    output int                                  o_error_count,
    output int                                  o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ADDR_W      = fprf_pkg::ADDR_W;
    localparam int          PAGES_W     = fprf_pkg::PAGES_W;
    localparam int          CFG_W       = fprf_pkg::CFG_W;
    localparam int          ENTRY_W     = fprf_pkg::ENTRY_W;
    localparam int          MAX_RANGES  = fprf_pkg::MAX_RANGES_DEF;
    localparam int          PAGE_SHIFT  = fprf_pkg::PAGE_SHIFT_DEF;
    localparam int unsigned SPACE_PAGES = 1 << (ADDR_W - PAGE_SHIFT);
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              not_found;
    } t_page_run;

    logic [ADDR_W-PAGE_SHIFT-1:0] start_pg [MAX_RANGES];
    logic [ADDR_W-PAGE_SHIFT:0]   end_pg   [MAX_RANGES];
    logic [CFG_W-1:0]             range_count = '0;
    t_page_run                    expected_runs [$];
    int                           mismatches = 0;
    int                           pending = 0;

    assign o_error_count   = mismatches;
    assign o_pending_count = pending;

    task automatic record_range(input logic [ENTRY_W-1:0] idx,
                                input logic [ADDR_W-1:0] rs,
                                input logic [ADDR_W-1:0] re);
        logic [ADDR_W:0] rounded;
        rounded = {1'b0, re} + ((ADDR_W+1)'(1) << PAGE_SHIFT) - 1'b1;
        if (int'(idx) < MAX_RANGES) begin
            start_pg[idx] = rs[ADDR_W-1:PAGE_SHIFT];
            end_pg[idx]   = rounded[ADDR_W:PAGE_SHIFT];
        end
    endtask

    // first fit, restarting the pass after any overlap
    function automatic t_page_run find_free_run(input logic [ADDR_W-1:0] start_addr,
                                                input logic [PAGES_W-1:0] want);
        int unsigned pg;
        int unsigned n;
        bit          moved;
        t_page_run   run;
        pg    = start_addr >> PAGE_SHIFT;
        n     = (int'(range_count) > MAX_RANGES) ? MAX_RANGES : range_count;
        run   = '{addr: '0, not_found: 1'b1};
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            if (pg + want > SPACE_PAGES) return run;
            for (int i = 0; i < n; i++) begin
                if (start_pg[i] < end_pg[i] && pg < end_pg[i] && pg + want > start_pg[i]) begin
                    pg    = end_pg[i];
                    moved = 1'b1;
                    if (pg + want > SPACE_PAGES) return run;
                end
            end
        end
        run.addr      = ADDR_W'(pg << PAGE_SHIFT);
        run.not_found = 1'b0;
        return run;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_page_run want;
        if (!i_rst_n) begin
            expected_runs.delete();
            range_count = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    log_mismatch($sformatf("result with none expected: found_address %h, not_found %b",
                                           i_found_address, i_not_found));
                end else begin
                    want = expected_runs.pop_front();
                    if (i_found_address !== want.addr)
                        log_mismatch($sformatf("found_address: expected %h, got %h",
                                               want.addr, i_found_address));
                    if (i_not_found !== want.not_found)
                        log_mismatch($sformatf("not_found: expected %b, got %b",
                                               want.not_found, i_not_found));
                end
            end
            if (i_cfg_we) range_count = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_func == fprf_pkg::FUNC_LOAD)
                    record_range(i_entry_index, i_range_start, i_range_end);
                else
                    expected_runs.push_back(find_free_run(i_search_start, i_page_count));
            end
        end
        pending = expected_runs.size();
    end

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the free page run finder.
// ----------------------------------------------------------------------------
// Fills the range table with hand-picked ranges, runs searches over the
// address extremes, then random phases that load ranges and search inside a
// narrow window so that overlaps and restarts are frequent. range_count is
// changed between phases once the block is idle. Both sides idle in random
// bursts, the receiver holds off once long enough for the block to back up,
// and the last phase runs without idling. fprf_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W       = fprf_pkg::ADDR_W;
    localparam int PAGES_W      = fprf_pkg::PAGES_W;
    localparam int CFG_W        = fprf_pkg::CFG_W;
    localparam int ENTRY_W      = fprf_pkg::ENTRY_W;
    localparam int PAGE_SHIFT   = fprf_pkg::PAGE_SHIFT_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 2000;
    localparam int PHASE_ITEMS  = 71;
    localparam int TIMEOUT_NS   = 10_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = fprf_pkg::FUNC_LOAD;
    logic [ENTRY_W-1:0] entry_index = '0;
    logic [ADDR_W-1:0]  range_start = '0;
    logic [ADDR_W-1:0]  range_end = '0;
    logic [ADDR_W-1:0]  search_start = '0;
    logic [PAGES_W-1:0] page_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ADDR_W-1:0]  found_address;
    logic               not_found;

    int                 searches_sent = 0;
    int                 results_seen = 0;
    int                 err_count;
    int                 pending_count;
    bit                 idle_off = 1'b0;
    bit                 long_hold_req = 1'b0;
    logic [ADDR_W-1:0]  window_base = '0;

    free_page_run_finder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_entry_index   (entry_index),
        .i_range_start   (range_start),
        .i_range_end     (range_end),
        .i_search_start  (search_start),
        .i_page_count    (page_count),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_found_address (found_address),
        .o_not_found     (not_found)
    );

    fprf_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (func),
        .i_entry_index   (entry_index),
        .i_range_start   (range_start),
        .i_range_end     (range_end),
        .i_search_start  (search_start),
        .i_page_count    (page_count),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_found_address (found_address),
        .i_not_found     (not_found),
        .o_error_count   (err_count),
        .o_pending_count (pending_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) results_seen <= results_seen + 1;
    end

    // result side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!idle_off && rst_n && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic f, input logic [ENTRY_W-1:0] idx,
                             input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] re,
                             input logic [ADDR_W-1:0] ss, input logic [PAGES_W-1:0] cnt);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        entry_index  <= idx;
        range_start  <= rs;
        range_end    <= re;
        search_start <= ss;
        page_count   <= cnt;
        do @(posedge clk); while (in_stall);
        if (f == fprf_pkg::FUNC_SEARCH) searches_sent++;
    endtask

    task automatic send_load(input logic [ENTRY_W-1:0] idx,
                             input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] re);
        send_item(fprf_pkg::FUNC_LOAD, idx, rs, re, $urandom, PAGES_W'($urandom));
    endtask

    task automatic send_search(input logic [ADDR_W-1:0] ss, input logic [PAGES_W-1:0] cnt);
        send_item(fprf_pkg::FUNC_SEARCH, ENTRY_W'($urandom), $urandom, $urandom, ss, cnt);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_seen != searches_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_range_count(input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count_cfg, input bit hold_off);
        logic [ADDR_W-1:0]  rs;
        logic [ADDR_W-1:0]  re;
        logic [ADDR_W-1:0]  ss;
        logic [PAGES_W-1:0] cnt;
        wait_idle();
        write_range_count(count_cfg);
        case ($urandom_range(0, 2))
            0: window_base = '0;
            1: window_base = 32'hFFF0_0000;
            default: window_base = {12'($urandom_range(0, 12'hFFE)), 20'h0};
        endcase
        if (hold_off) long_hold_req = 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 9) < 3) begin
                rs = window_base + $urandom_range(0, 32'h7_FFFF);
                case ($urandom_range(0, 19))
                    0, 1: re = rs - $urandom_range(0, 32'h3000);
                    2: begin
                        rs = $urandom;
                        re = $urandom;
                    end
                    3: if ($urandom_range(0, 3) == 0) begin
                        rs = '0;
                        re = '1;
                    end else begin
                        re = rs + $urandom_range(32'h1_0000, 32'h4_0000);
                    end
                    default: re = rs + $urandom_range(1, 32'h1_0000);
                endcase
                send_load(ENTRY_W'($urandom), rs, re);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    ss = $urandom;
                else
                    ss = window_base + {20'($urandom_range(0, 127)), 12'h0};
                if ($urandom_range(0, 4) == 0) ss[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                case ($urandom_range(0, 19))
                    0: cnt = '0;
                    1: cnt = '1;
                    2: cnt = PAGES_W'($urandom);
                    3, 4: cnt = PAGES_W'($urandom_range(1, 4096));
                    default: cnt = PAGES_W'($urandom_range(1, 24));
                endcase
                send_search(ss, cnt);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_range_count(5'd0);

        // full table: chained overlaps, empty and inverted ranges, top page
        send_load(4'd0,  32'h0000_0000, 32'h0000_1000);
        send_load(4'd1,  32'h0000_3800, 32'h0000_5001);
        send_load(4'd2,  32'h0001_0000, 32'h0000_8000);
        send_load(4'd3,  32'h0000_1000, 32'h0000_2FFF);
        send_load(4'd4,  32'hFFFF_F000, 32'hFFFF_FFFF);
        send_load(4'd5,  32'h8000_0000, 32'h8000_0000);
        send_load(4'd6,  32'h0000_6000, 32'h0000_7000);
        send_load(4'd7,  32'h0001_0FFF, 32'h0002_0001);
        send_load(4'd8,  32'h0000_0000, 32'h0000_0000);
        send_load(4'd9,  32'h0000_8000, 32'h0000_9000);
        send_load(4'd10, 32'h4000_0000, 32'h7FFF_FFFF);
        send_load(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(4'd12, 32'h0002_5000, 32'h0002_6000);
        send_load(4'd13, 32'h0010_0000, 32'h0020_0000);
        send_load(4'd14, 32'h0003_0000, 32'h0003_1000);
        send_load(4'd15, 32'h00FF_F001, 32'h0100_0000);

        // no valid entries: only the end of the space limits the answer
        send_search(32'h0000_0000, 13'd0);
        send_search(32'hFFFF_FFFF, 13'd1);
        send_search(32'hFFFF_F000, 13'd2);
        send_search(32'h0000_0ABC, 13'h1FFF);
        wait_idle();

        write_range_count(5'd16);
        send_search(32'h0000_0000, 13'd1);
        send_search(32'h0000_0000, 13'd3);
        send_search(32'hFFFF_F123, 13'd0);
        send_search(32'hFFFF_F000, 13'd1);
        send_search(32'h3FFF_F000, 13'h1000);

        run_phase(5'd31, 1'b1);
        run_phase(5'd0, 1'b0);
        run_phase(5'd1, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 15)), 1'b0);
        run_phase(5'd16, 1'b0);
        idle_off = 1'b1;
        run_phase(CFG_W'($urandom_range(17, 30)), 1'b0);
        wait_idle();

        if (err_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

[free_page_run_finder.f]
hdl/fprf_pkg.sv
hdl/fprf_dp.sv
hdl/fprf_ctrl.sv
hdl/free_page_run_finder.sv
dv/fprf_checker.sv
dv/tb_top.sv
